### hdl/vad_pkg.sv
// Package for the vector angle and distance block.
// Holds the request and response types, the pipeline cell type, the fixed-point
// constants and the arctangent table. It depends on nothing else.
package vad_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int CORDIC_STAGES   = 16;

   localparam int GUARD_BITS  = 16;
   localparam int Z_FRAC      = 30;
   localparam int ANGLE_OUT_W = 17;
   localparam int DIST_OUT_W  = 21;
   localparam int STAGE_IDX_W = 5;

   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int XW     = DIFF_W + GUARD_BITS + 3;
   localparam int ZW     = 34;

   localparam int XL_W   = 25;
   localparam int XH_W   = XW - XL_W;
   localparam int GAIN_W = 32;
   localparam int PLO_W  = XL_W + GAIN_W;
   localparam int PHI_W  = XH_W + GAIN_W;
   localparam int T_W    = PHI_W + 1;
   localparam int DIST_SHIFT = 19;
   localparam int D_W    = T_W - DIST_SHIFT;

   localparam longint PI_Q30_L      = 64'sd3373259426;
   localparam longint HALF_PI_Q30_L = 64'sd1686629713;
   localparam int     ANG_SHIFT     = Z_FRAC - ANGLE_FRAC_BITS;
   localparam longint ANG_HALF_L    = 64'sd1 <<< (ANG_SHIFT - 1);

   localparam longint ANG_POS_L = (HALF_PI_Q30_L + ANG_HALF_L) >>> ANG_SHIFT;
   localparam longint ANG_LO_L  = -ANG_POS_L;
   localparam longint ANG_HI_L  = (3 * HALF_PI_Q30_L + ANG_HALF_L) >>> ANG_SHIFT;
   localparam longint AMIN_L    = -(64'sd1 <<< (ANGLE_OUT_W - 1));
   localparam longint AMAX_L    = (64'sd1 <<< (ANGLE_OUT_W - 1)) - 1;
   localparam longint ANG_MIN_L = (ANG_LO_L > AMIN_L) ? ANG_LO_L : AMIN_L;
   localparam longint ANG_MAX_L = (ANG_HI_L < AMAX_L) ? ANG_HI_L : AMAX_L;
   localparam longint ANG_UP_L  = (ANG_POS_L < ANG_MAX_L) ? ANG_POS_L : ANG_MAX_L;

   localparam logic signed [ZW-1:0] PI_Q30   = ZW'(PI_Q30_L);
   localparam logic signed [ZW-1:0] ANG_HALF = ZW'(ANG_HALF_L);
   localparam logic signed [ZW-1:0] ANG_MIN  = ZW'(ANG_MIN_L);
   localparam logic signed [ZW-1:0] ANG_MAX  = ZW'(ANG_MAX_L);
   localparam logic signed [ZW-1:0] ANG_UP   = ZW'(ANG_UP_L);

   localparam logic [GAIN_W-1:0]     INV_GAIN_Q32 = 32'd2608131496;
   localparam logic [T_W-1:0]        DIST_ROUND   = T_W'(64'd1 << (DIST_SHIFT - 1));
   localparam logic [DIST_OUT_W-1:0] DIST_MAX     = {DIST_OUT_W{1'b1}};

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] first_x;
      logic signed [COORD_WIDTH-1:0] first_y;
      logic signed [COORD_WIDTH-1:0] second_x;
      logic signed [COORD_WIDTH-1:0] second_y;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_OUT_W-1:0] angle_rad;
      logic [DIST_OUT_W-1:0]         distance;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic                 vert;
      logic                 dy_pos;
      logic                 neg;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [STAGE_IDX_W-1:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:  v = ZW'(64'sd843314857);
         5'd1:  v = ZW'(64'sd497837829);
         5'd2:  v = ZW'(64'sd263043837);
         5'd3:  v = ZW'(64'sd133525159);
         5'd4:  v = ZW'(64'sd67021687);
         5'd5:  v = ZW'(64'sd33543516);
         5'd6:  v = ZW'(64'sd16775851);
         5'd7:  v = ZW'(64'sd8388437);
         5'd8:  v = ZW'(64'sd4194283);
         5'd9:  v = ZW'(64'sd2097149);
         5'd10: v = ZW'(64'sd1048576);
         5'd11: v = ZW'(64'sd524288);
         5'd12: v = ZW'(64'sd262144);
         5'd13: v = ZW'(64'sd131072);
         5'd14: v = ZW'(64'sd65536);
         5'd15: v = ZW'(64'sd32768);
         5'd16: v = ZW'(64'sd16384);
         5'd17: v = ZW'(64'sd8192);
         5'd18: v = ZW'(64'sd4096);
         5'd19: v = ZW'(64'sd2048);
         5'd20: v = ZW'(64'sd1024);
         5'd21: v = ZW'(64'sd512);
         5'd22: v = ZW'(64'sd256);
         5'd23: v = ZW'(64'sd128);
         5'd24: v = ZW'(64'sd64);
         5'd25: v = ZW'(64'sd32);
         5'd26: v = ZW'(64'sd16);
         5'd27: v = ZW'(64'sd8);
         5'd28: v = ZW'(64'sd4);
         5'd29: v = ZW'(64'sd2);
         5'd30: v = ZW'(64'sd1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### hdl/vad_prep.sv
// Entry stage of the vector angle and distance pipeline.
// Forms the difference vector, folds it into the right half plane and loads
// the first cell register. Depends on vad_pkg.
module vad_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                req_valid,
   input  vad_pkg::req_type    req_payload,
   output vad_pkg::cordic_type cell_out
);
   import vad_pkg::*;

   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic signed [DIFF_W-1:0] x_start;
   logic signed [DIFF_W-1:0] y_start;
   logic                     valid_ff;
   cordic_type               data_ff;
   cordic_type               data_in;

   assign dx = DIFF_W'(req_payload.second_x) - DIFF_W'(req_payload.first_x);
   assign dy = DIFF_W'(req_payload.second_y) - DIFF_W'(req_payload.first_y);

   always_comb begin
      if (dx[DIFF_W-1]) begin
         x_start = -dx;
         y_start = dy;
      end else begin
         x_start = dx;
         y_start = -dy;
      end
      data_in        = '0;
      data_in.vert   = (dx == '0);
      data_in.dy_pos = !dy[DIFF_W-1] && (dy != '0);
      data_in.neg    = dx[DIFF_W-1];
      data_in.x      = XW'(x_start) <<< GUARD_BITS;
      data_in.y      = XW'(y_start) <<< GUARD_BITS;
      data_in.z      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end

endmodule

### hdl/vad_cell.sv
// One CORDIC vectoring cell: a single micro-rotation followed by a register.
// The cell's position in the chain sets the shift and the arctangent step.
// Depends on vad_pkg.
module vad_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic [vad_pkg::STAGE_IDX_W-1:0] stage_idx,
   input  vad_pkg::cordic_type           cell_in,
   output vad_pkg::cordic_type           cell_out
);
   import vad_pkg::*;

   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;
   logic signed [ZW-1:0] step;
   logic                 valid_ff;
   cordic_type           data_ff;
   cordic_type           data_in;

   assign xs   = cell_in.x >>> stage_idx;
   assign ys   = cell_in.y >>> stage_idx;
   assign step = atan_q30(stage_idx);

   always_comb begin
      data_in = cell_in;
      if (!cell_in.y[XW-1]) begin
         data_in.x = cell_in.x + ys;
         data_in.y = cell_in.y - xs;
         data_in.z = cell_in.z + step;
      end else begin
         data_in.x = cell_in.x - ys;
         data_in.y = cell_in.y + xs;
         data_in.z = cell_in.z - step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end

endmodule

### hdl/vad_post.sv
// Output stages: angle rounding and clamping, and gain correction of the
// final x by a split multiply over three registered steps. Depends on vad_pkg.
module vad_post (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  vad_pkg::cordic_type cell_in,
   output logic                rsp_valid,
   output vad_pkg::rsp_type    rsp_payload
);
   import vad_pkg::*;

   logic signed [ZW-1:0]          ang_sum;
   logic signed [ZW-1:0]          ang_rnd;
   logic signed [ZW-1:0]          ang_sel;
   logic signed [ZW-1:0]          ang_clip;
   logic [XW-1:0]                 ux;
   logic [T_W-1:0]                t_sum;
   logic [T_W-1:0]                t_rnd;
   logic [D_W-1:0]                dist_full;

   logic                          valid1_ff;
   logic                          valid2_ff;
   logic                          valid3_ff;
   logic signed [ANGLE_OUT_W-1:0] ang1_ff;
   logic signed [ANGLE_OUT_W-1:0] ang2_ff;
   logic [XH_W-1:0]               xh1_ff;
   logic [PLO_W-1:0]              plo1_ff;
   logic [PHI_W-1:0]              phi2_ff;
   logic [GAIN_W-1:0]             plo2_ff;
   rsp_type                       rsp_ff;
   rsp_type                       rsp_in;

   always_comb begin
      ang_sum = (cell_in.neg ? PI_Q30 : ZW'(0)) + cell_in.z;
      ang_rnd = (ang_sum + ANG_HALF) >>> ANG_SHIFT;
      if (cell_in.vert) begin
         ang_sel = cell_in.dy_pos ? ANG_MIN : ANG_UP;
      end else begin
         ang_sel = ang_rnd;
      end
      if (ang_sel < ANG_MIN) begin
         ang_clip = ANG_MIN;
      end else if (ang_sel > ANG_MAX) begin
         ang_clip = ANG_MAX;
      end else begin
         ang_clip = ang_sel;
      end
      ux = cell_in.x[XW-1] ? '0 : XW'(cell_in.x);
   end

   always_comb begin
      t_sum     = T_W'(phi2_ff) + T_W'(plo2_ff);
      t_rnd     = t_sum + DIST_ROUND;
      dist_full = t_rnd[T_W-1:DIST_SHIFT];
      rsp_in.angle_rad = ang2_ff;
      if (dist_full > D_W'(DIST_MAX)) begin
         rsp_in.distance = DIST_MAX;
      end else begin
         rsp_in.distance = dist_full[DIST_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= cell_in.valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ang1_ff <= ang_clip[ANGLE_OUT_W-1:0];
         xh1_ff  <= ux[XW-1:XL_W];
         plo1_ff <= PLO_W'(ux[XL_W-1:0]) * PLO_W'(INV_GAIN_Q32);
         ang2_ff <= ang1_ff;
         phi2_ff <= PHI_W'(xh1_ff) * PHI_W'(INV_GAIN_Q32);
         plo2_ff <= plo1_ff[PLO_W-1:XL_W];
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_valid   = valid3_ff;
   assign rsp_payload = rsp_ff;

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ZW'(rsp_payload.angle_rad) >= ANG_MIN)
                 && (ZW'(rsp_payload.angle_rad) <= ANG_MAX))
      else $error("Response angle lies outside its clamped range.");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !enable) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("A held response changed or was dropped.");

   a_advance : assert property (@(posedge clock) disable iff (reset)
      (valid2_ff && enable) |=> rsp_valid)
      else $error("A request was lost in the output stages.");

endmodule

### hdl/vector_angle_and_distance.sv
// Top level of the vector angle and distance block.
// Chains the entry stage, the CORDIC cells and the output stages. Depends on
// vad_pkg, vad_prep, vad_cell and vad_post.
//
// The block takes one request per clock cycle while req_stall is low and returns
// one response per request, in order. A request passes through one entry
// register, one register per CORDIC cell and three output registers for the
// split gain-correction multiply. When the response is stalled the whole
// pipeline holds, and the request side is stalled in the same cycle.
module vector_angle_and_distance (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vad_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vad_pkg::rsp_type rsp_payload
);
   import vad_pkg::*;

   logic       enable;
   cordic_type chain [CORDIC_STAGES+1];

   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   vad_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .cell_out    (chain[0])
   );

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      vad_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage_idx (STAGE_IDX_W'(k)),
         .cell_in   (chain[k]),
         .cell_out  (chain[k+1])
      );
   end

   vad_post u_post (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .cell_in     (chain[CORDIC_STAGES]),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
